/* sv/sensorless_bldc_commutation_unit_macros.svh */
// Assertion macros used by the port-level checker file of the commutation unit.
`ifndef SENSORLESS_BLDC_COMMUTATION_UNIT_MACROS_SVH
`define SENSORLESS_BLDC_COMMUTATION_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define SBC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define SBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sbc_pkg.sv */
// Shared constants, types and phase tables of the commutation unit.
package sbc_pkg;

	localparam int unsigned HIST_DEPTH = 8;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned PER_W      = 13;
	localparam int unsigned BLANK_W    = 16;
	localparam int unsigned DLY_W      = 16;
	localparam int unsigned STEP_W     = 3;
	localparam int unsigned PHASE_W    = 2;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned SLOT_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int unsigned SUM_W   = PER_W + $clog2(HIST_DEPTH);
	// mean/2 as a multiply by a rounded-up reciprocal, exact for every SUM_W-bit sum
	localparam int unsigned AVG_DIV = 2 * HIST_DEPTH;
	localparam int unsigned AVG_SH  = SUM_W + $clog2(AVG_DIV);
	localparam int unsigned RECIP_W = SUM_W + 1;
	localparam int unsigned PROD_W  = SUM_W + RECIP_W;
	localparam longint unsigned AVG_RECIP = ((64'd1 << AVG_SH) + AVG_DIV - 1) / AVG_DIV;

	localparam logic [PER_W-1:0]   RST_MAX_PERIOD   = PER_W'(8000);
	localparam logic [PER_W-1:0]   RST_GOOD_MIN     = PER_W'(40);
	localparam logic [PER_W-1:0]   RST_GOOD_MAX     = PER_W'(1000);
	localparam logic [PER_W-1:0]   RST_LAG_THRESH   = PER_W'(80);
	localparam logic [PER_W-1:0]   RST_LAG_OFFSET   = PER_W'(40);
	localparam logic [PER_W-1:0]   RST_MIN_DELAY    = PER_W'(20);
	localparam logic [BLANK_W-1:0] RST_BLANK        = BLANK_W'(80);
	localparam logic [PER_W-1:0]   RST_START_PERIOD = PER_W'(400);
	localparam logic [PER_W-1:0]   RST_PERIOD_US    = PER_W'(400);
	localparam logic [SUM_W-1:0]   RST_SUM          = SUM_W'(400 * HIST_DEPTH);

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(5);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_PERIOD = CFG_IDX_W'(0),
		CFG_GOOD_MIN,
		CFG_GOOD_MAX,
		CFG_LAG_THRESH,
		CFG_LAG_OFFSET,
		CFG_MIN_DELAY,
		CFG_BLANK,
		CFG_START_PERIOD
	} cfg_idx_t;

	typedef struct packed {
		logic [PER_W-1:0]   max_period;
		logic [PER_W-1:0]   good_min;
		logic [PER_W-1:0]   good_max;
		logic [PER_W-1:0]   lag_thresh;
		logic [PER_W-1:0]   lag_offset;
		logic [PER_W-1:0]   min_delay;
		logic [BLANK_W-1:0] blank;
		logic [PER_W-1:0]   start_period;
		logic [SUM_W-1:0]   fill_sum;
	} cfg_t;

	typedef struct packed {
		logic             capture;
		logic             restart;
		logic [PER_W-1:0] period;
	} hist_cmd_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_A = PHASE_W'(0),
		PH_B = PHASE_W'(1),
		PH_C = PHASE_W'(2)
	} phase_t;

	function automatic logic [PHASE_W-1:0] phase_high(input logic [STEP_W-1:0] step);
		logic [PHASE_W-1:0] ph;
		case (step)
			STEP_W'(0), STEP_W'(1): ph = PH_A;
			STEP_W'(2), STEP_W'(3): ph = PH_B;
			STEP_W'(4), STEP_W'(5): ph = PH_C;
			default:                ph = PH_A;
		endcase
		return ph;
	endfunction

	function automatic logic [PHASE_W-1:0] phase_low(input logic [STEP_W-1:0] step);
		logic [PHASE_W-1:0] ph;
		case (step)
			STEP_W'(0), STEP_W'(5): ph = PH_B;
			STEP_W'(1), STEP_W'(2): ph = PH_C;
			STEP_W'(3), STEP_W'(4): ph = PH_A;
			default:                ph = PH_B;
		endcase
		return ph;
	endfunction

	function automatic logic [PHASE_W-1:0] phase_sense(input logic [STEP_W-1:0] step);
		logic [PHASE_W-1:0] ph;
		case (step)
			STEP_W'(0), STEP_W'(3): ph = PH_C;
			STEP_W'(1), STEP_W'(4): ph = PH_B;
			STEP_W'(2), STEP_W'(5): ph = PH_A;
			default:                ph = PH_C;
		endcase
		return ph;
	endfunction

endpackage

/* sv/sbc_if.sv */
// Tick, result and configuration channel interfaces of the commutation unit.
interface sbc_tick_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic                        zero_cross;
	logic                        run_enable;
	logic [sbc_pkg::STEP_W-1:0]  start_step;

	modport source (output valid, opcode, zero_cross, run_enable, start_step, input ready);
	modport sink (input valid, opcode, zero_cross, run_enable, start_step, output ready);
endinterface

interface sbc_result_if;
	logic                        valid;
	logic                        ready;
	logic [sbc_pkg::STEP_W-1:0]  step_now;
	logic                        commutated;
	logic [sbc_pkg::PHASE_W-1:0] high_phase;
	logic [sbc_pkg::PHASE_W-1:0] low_phase;
	logic [sbc_pkg::PHASE_W-1:0] sense_phase;
	logic                        edge_rising;
	logic                        healthy_rotation;
	logic [sbc_pkg::PER_W-1:0]   average_half_period;

	modport source (output valid, step_now, commutated, high_phase, low_phase, sense_phase,
		edge_rising, healthy_rotation, average_half_period, input ready);
	modport sink (input valid, step_now, commutated, high_phase, low_phase, sense_phase,
		edge_rising, healthy_rotation, average_half_period, output ready);
endinterface

interface sbc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sbc_pkg::CFG_IDX_W-1:0]  index;
	logic [sbc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/sbc_cfg_regs.sv */
// Configuration register file with the precomputed history fill sum.
module sbc_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	sbc_cfg_if.sink         cfg,
	output sbc_pkg::cfg_t   regs
);

	sbc_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.max_period   <= sbc_pkg::RST_MAX_PERIOD;
			regs_q.good_min     <= sbc_pkg::RST_GOOD_MIN;
			regs_q.good_max     <= sbc_pkg::RST_GOOD_MAX;
			regs_q.lag_thresh   <= sbc_pkg::RST_LAG_THRESH;
			regs_q.lag_offset   <= sbc_pkg::RST_LAG_OFFSET;
			regs_q.min_delay    <= sbc_pkg::RST_MIN_DELAY;
			regs_q.blank        <= sbc_pkg::RST_BLANK;
			regs_q.start_period <= sbc_pkg::RST_START_PERIOD;
			regs_q.fill_sum     <= sbc_pkg::RST_SUM;
		end else begin
			// restart sum is registered from the start period, so it lags a write by one register
			regs_q.fill_sum <= sbc_pkg::SUM_W'(regs_q.start_period)
				* sbc_pkg::SUM_W'(sbc_pkg::HIST_DEPTH);
			if (cfg.valid) begin
				unique case (sbc_pkg::cfg_idx_t'(cfg.index))
					sbc_pkg::CFG_MAX_PERIOD:   regs_q.max_period   <= cfg.data[sbc_pkg::PER_W-1:0];
					sbc_pkg::CFG_GOOD_MIN:     regs_q.good_min     <= cfg.data[sbc_pkg::PER_W-1:0];
					sbc_pkg::CFG_GOOD_MAX:     regs_q.good_max     <= cfg.data[sbc_pkg::PER_W-1:0];
					sbc_pkg::CFG_LAG_THRESH:   regs_q.lag_thresh   <= cfg.data[sbc_pkg::PER_W-1:0];
					sbc_pkg::CFG_LAG_OFFSET:   regs_q.lag_offset   <= cfg.data[sbc_pkg::PER_W-1:0];
					sbc_pkg::CFG_MIN_DELAY:    regs_q.min_delay    <= cfg.data[sbc_pkg::PER_W-1:0];
					sbc_pkg::CFG_BLANK:        regs_q.blank        <= cfg.data[sbc_pkg::BLANK_W-1:0];
					sbc_pkg::CFG_START_PERIOD: regs_q.start_period <= cfg.data[sbc_pkg::PER_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

/* sv/sbc_history.sv */
// Period history with running sum and the averaged half period.
module sbc_history (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sbc_pkg::hist_cmd_t        cmd,
	input  sbc_pkg::cfg_t             regs,
	output logic [sbc_pkg::PER_W-1:0] avg_next
);

	logic [sbc_pkg::PER_W-1:0]  hist_q [sbc_pkg::HIST_DEPTH];
	logic [sbc_pkg::SUM_W-1:0]  sum_q;
	logic [sbc_pkg::SUM_W-1:0]  sum_d;
	logic [sbc_pkg::SLOT_W-1:0] slot_q;
	logic [sbc_pkg::SLOT_W-1:0] slot_d;
	logic [sbc_pkg::PROD_W-1:0] prod;

	always_comb begin
		sum_d  = sum_q;
		slot_d = slot_q;
		if (cmd.restart) begin
			sum_d = regs.fill_sum;
		end else if (cmd.capture) begin
			sum_d  = sum_q - sbc_pkg::SUM_W'(hist_q[slot_q]) + sbc_pkg::SUM_W'(cmd.period);
			slot_d = (slot_q == sbc_pkg::SLOT_W'(sbc_pkg::HIST_DEPTH - 1))
				? '0 : slot_q + 1'b1;
		end
		prod     = sbc_pkg::PROD_W'(sum_d) * sbc_pkg::PROD_W'(sbc_pkg::AVG_RECIP);
		avg_next = sbc_pkg::PER_W'(prod >> sbc_pkg::AVG_SH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sbc_pkg::HIST_DEPTH; i++) begin
				hist_q[i] <= sbc_pkg::RST_PERIOD_US;
			end
			sum_q  <= sbc_pkg::RST_SUM;
			slot_q <= '0;
		end else begin
			sum_q  <= sum_d;
			slot_q <= slot_d;
			if (cmd.restart) begin
				for (int i = 0; i < sbc_pkg::HIST_DEPTH; i++) begin
					hist_q[i] <= regs.start_period;
				end
			end else if (cmd.capture) begin
				hist_q[slot_q] <= cmd.period;
			end
		end
	end

endmodule

/* sv/sbc_sequencer.sv */
// Period counter, delay and blanking timer, and six-step commutation state.
module sbc_sequencer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic                       opcode,
	input  logic                       zero_cross,
	input  logic                       run_enable,
	input  logic [sbc_pkg::STEP_W-1:0] start_step,
	input  sbc_pkg::cfg_t              regs,
	input  logic [sbc_pkg::PER_W-1:0]  avg_next,
	output sbc_pkg::hist_cmd_t         cmd,
	output logic [sbc_pkg::STEP_W-1:0] step_next,
	output logic                       commutated
);

	typedef enum logic [1:0] {
		BP_READY,
		BP_DELAY,
		BP_BLANK
	} blank_phase_t;

	blank_phase_t                phase_q, phase_d;
	logic [sbc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic                        ovf_q, ovf_d;
	logic [sbc_pkg::DLY_W-1:0]   dly_q, dly_d;
	logic [sbc_pkg::STEP_W-1:0]  step_q;
	logic [sbc_pkg::CNT_W-2:0]   half;
	logic [sbc_pkg::PER_W-1:0]   period;
	logic [sbc_pkg::PER_W-1:0]   delay_us;
	logic [sbc_pkg::DLY_W-1:0]   delay_load;
	logic [sbc_pkg::DLY_W-1:0]   blank_load;

	always_comb begin
		half = cnt_q[sbc_pkg::CNT_W-1:1];
		if (ovf_q || (32'(half) >= 32'(regs.max_period))) begin
			period = regs.max_period;
		end else begin
			period = sbc_pkg::PER_W'(half);
		end

		// 30-degree delay less the lag, floored to the minimum below the threshold or when the lag is not below it
		if ((avg_next >= regs.lag_thresh) && (avg_next > regs.lag_offset)) begin
			delay_us = avg_next - regs.lag_offset;
		end else begin
			delay_us = regs.min_delay;
		end
		delay_load = {sbc_pkg::DLY_W'(delay_us), 1'b0} == '0 ? sbc_pkg::DLY_W'(1)
			: sbc_pkg::DLY_W'({delay_us, 1'b0});
		blank_load = (regs.blank == '0) ? sbc_pkg::DLY_W'(1) : sbc_pkg::DLY_W'(regs.blank);

		cnt_d       = cnt_q;
		ovf_d       = ovf_q;
		phase_d     = phase_q;
		dly_d       = dly_q;
		step_next   = step_q;
		commutated  = 1'b0;
		cmd.capture = 1'b0;
		cmd.restart = 1'b0;
		cmd.period  = period;

		if (go) begin
			if (opcode) begin
				step_next   = (start_step > sbc_pkg::STEP_LAST) ? '0 : start_step;
				cmd.restart = 1'b1;
				phase_d     = BP_READY;
				dly_d       = '0;
			end else if (zero_cross && (phase_q == BP_READY)) begin
				cmd.capture = 1'b1;
				cnt_d       = '0;
				ovf_d       = 1'b0;
				dly_d       = delay_load;
				phase_d     = BP_DELAY;
			end else begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_d == '0) begin
					ovf_d = 1'b1;
				end
				if (dly_q != '0) begin
					dly_d = dly_q - 1'b1;
					if (dly_q == sbc_pkg::DLY_W'(1)) begin
						unique case (phase_q)
							BP_DELAY: begin
								phase_d = BP_BLANK;
								dly_d   = blank_load;
								if (run_enable) begin
									step_next  = (step_q >= sbc_pkg::STEP_LAST) ? '0
										: step_q + 1'b1;
									commutated = 1'b1;
								end
							end
							BP_BLANK: phase_d = BP_READY;
							default: ;
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= BP_READY;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			dly_q   <= '0;
			step_q  <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
			dly_q   <= dly_d;
			step_q  <= step_next;
		end
	end

endmodule

/* sv/sensorless_bldc_commutation_unit.sv */
// Top level of the sensorless six-step commutation unit.
//
// tick carries one timer count per request (two counts per microsecond): a restart
// opcode, the back-EMF zero-cross flag, the run flag and the restart step.
// result returns exactly one item per tick, describing the state after it: step,
// commutation strobe, drive and sense phases, edge polarity, rotation health and
// the averaged half period.
// cfg writes one register per request; it is always ready and must only be used
// while no tick is in flight.
// A tick is first taken into the input register; the state update and the result
// register follow once the result side can advance, so a result stall can come
// between the two.
// Throughput is one tick per cycle while the result is not stalled.
// When result is stalled the result register holds and one more tick is still
// taken into the input register; tick.ready drops only when both are full.
// Reset clears both stages, loads the register defaults, fills the history with
// 400 us and stops the delay timer.
module sensorless_bldc_commutation_unit (
	input  logic          clk,
	input  logic          arst_n,
	sbc_tick_if.sink      tick,
	sbc_result_if.source  result,
	sbc_cfg_if.sink       cfg
);

	typedef struct packed {
		logic                       opcode;
		logic                       zero_cross;
		logic                       run_enable;
		logic [sbc_pkg::STEP_W-1:0] start_step;
	} item_t;

	typedef struct packed {
		logic [sbc_pkg::STEP_W-1:0]  step_now;
		logic                        commutated;
		logic [sbc_pkg::PHASE_W-1:0] high_phase;
		logic [sbc_pkg::PHASE_W-1:0] low_phase;
		logic [sbc_pkg::PHASE_W-1:0] sense_phase;
		logic                        edge_rising;
		logic                        healthy_rotation;
		logic [sbc_pkg::PER_W-1:0]   average_half_period;
	} result_t;

	sbc_pkg::cfg_t               regs;
	sbc_pkg::hist_cmd_t          cmd;
	item_t                       item_s1;
	logic                        valid_s1;
	result_t                     res_d, res_q;
	logic                        res_valid_q;
	logic                        advance;
	logic                        go;
	logic [sbc_pkg::PER_W-1:0]   avg_next;
	logic [sbc_pkg::STEP_W-1:0]  step_next;
	logic                        commutated;

	assign advance    = !res_valid_q || result.ready;
	assign go         = valid_s1 && advance;
	assign tick.ready = !valid_s1 || advance;

	sbc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sbc_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.opcode     (item_s1.opcode),
		.zero_cross (item_s1.zero_cross),
		.run_enable (item_s1.run_enable),
		.start_step (item_s1.start_step),
		.regs       (regs),
		.avg_next   (avg_next),
		.cmd        (cmd),
		.step_next  (step_next),
		.commutated (commutated)
	);

	sbc_history u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.regs     (regs),
		.avg_next (avg_next)
	);

	always_comb begin
		res_d.step_now            = step_next;
		res_d.commutated          = commutated;
		res_d.high_phase          = sbc_pkg::phase_high(step_next);
		res_d.low_phase           = sbc_pkg::phase_low(step_next);
		res_d.sense_phase         = sbc_pkg::phase_sense(step_next);
		res_d.edge_rising         = step_next[0];
		res_d.healthy_rotation    = (avg_next >= regs.good_min) && (avg_next <= regs.good_max);
		res_d.average_half_period = avg_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (tick.ready) begin
				valid_s1 <= tick.valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1.opcode     <= tick.opcode;
			item_s1.zero_cross <= tick.zero_cross;
			item_s1.run_enable <= tick.run_enable;
			item_s1.start_step <= tick.start_step;
		end
		if (go) begin
			res_q <= res_d;
		end
	end

	assign result.valid               = res_valid_q;
	assign result.step_now            = res_q.step_now;
	assign result.commutated          = res_q.commutated;
	assign result.high_phase          = res_q.high_phase;
	assign result.low_phase           = res_q.low_phase;
	assign result.sense_phase         = res_q.sense_phase;
	assign result.edge_rising         = res_q.edge_rising;
	assign result.healthy_rotation    = res_q.healthy_rotation;
	assign result.average_half_period = res_q.average_half_period;

endmodule

/* sv/sbc_checker.sv */
// Port-level checker of the commutation unit and its bind to the top level.
`include "sensorless_bldc_commutation_unit_macros.svh"

module sbc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       tick_valid,
	input logic                       tick_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [sbc_pkg::STEP_W-1:0] res_step_now,
	input logic                       res_commutated,
	input logic [sbc_pkg::PER_W-1:0]  res_avg
);

	logic [sbc_pkg::STEP_W+sbc_pkg::PER_W:0] res_payload;

	assign res_payload = {res_step_now, res_commutated, res_avg};

	// an empty result register must never block the tick channel
	`SBC_ASSERT_IMP(a_ready_when_drained, !res_valid, tick_ready, "tick stalled with result empty")

	// a stalled result request holds its payload
	`SBC_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(res_payload), "stalled result changed")

	// a taken tick passes the input and result registers and shows up as a valid result when the receiver keeps up
	`SBC_ASSERT_NEXT(a_latency, (tick_valid && tick_ready) ##1 res_ready, res_valid, "result missing after accepted tick")

endmodule

bind sensorless_bldc_commutation_unit sbc_checker u_sbc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.tick_valid     (tick.valid),
	.tick_ready     (tick.ready),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_step_now   (result.step_now),
	.res_commutated (result.commutated),
	.res_avg        (result.average_half_period)
);

/* test/sbc_commutation_checker.sv */
// Checker for the commutation unit: watches the channels, predicts each result and compares.
module sbc_commutation_checker import sbc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	sbc_tick_if   tick,
	sbc_result_if result,
	sbc_cfg_if    cfg,
	output int    mismatches,
	output int    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		ZC_ARMED,
		ZC_DELAY,
		ZC_BLANK
	} zc_window_t;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic              commutated;
		phase_t            hi_ph;
		phase_t            lo_ph;
		phase_t            sn_ph;
		logic              rising;
		logic              healthy;
		logic [PER_W-1:0]  avg;
	} drive_word_t;

	localparam phase_t HIGH_OF_STEP [0:5] = '{PH_A, PH_A, PH_B, PH_B, PH_C, PH_C};
	localparam phase_t LOW_OF_STEP  [0:5] = '{PH_B, PH_C, PH_C, PH_A, PH_A, PH_B};
	localparam phase_t SENSE_OF_STEP[0:5] = '{PH_C, PH_B, PH_A, PH_C, PH_B, PH_A};

	// register copies
	logic [PER_W-1:0]   lim_period, good_lo, good_hi, lag_thr, lag_off, dly_min, start_per;
	logic [BLANK_W-1:0] blank_len;

	// timing state
	logic [CNT_W-1:0]  period_cnt;
	logic              cnt_wrapped;
	logic [PER_W-1:0]  hist [HIST_DEPTH];
	logic [SUM_W-1:0]  hist_sum;
	logic [SLOT_W-1:0] hist_slot;
	zc_window_t        window;
	logic [DLY_W-1:0]  dly_left;
	logic [STEP_W-1:0] step;

	drive_word_t pending_drive[$];
	drive_word_t want;

	task automatic clear_model();
		lim_period = RST_MAX_PERIOD;
		good_lo    = RST_GOOD_MIN;
		good_hi    = RST_GOOD_MAX;
		lag_thr    = RST_LAG_THRESH;
		lag_off    = RST_LAG_OFFSET;
		dly_min    = RST_MIN_DELAY;
		blank_len  = RST_BLANK;
		start_per  = RST_START_PERIOD;
		period_cnt  = '0;
		cnt_wrapped = 1'b0;
		for (int i = 0; i < HIST_DEPTH; i++)
			hist[i] = RST_PERIOD_US;
		hist_sum  = RST_SUM;
		hist_slot = '0;
		window    = ZC_ARMED;
		dly_left  = '0;
		step      = '0;
	endtask

	function automatic drive_word_t predict_drive(input logic op, input logic zc,
			input logic run, input logic [STEP_W-1:0] ss);
		drive_word_t      w;
		logic [PER_W-1:0] per;
		logic [PER_W-1:0] avg_now;
		logic [PER_W-1:0] dly_us;
		logic             advanced;
		advanced = 1'b0;
		if (op) begin
			step = (ss > STEP_LAST) ? '0 : ss;
			hist_sum = '0;
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist[i] = start_per;
				hist_sum = hist_sum + SUM_W'(start_per);
			end
			window   = ZC_ARMED;
			dly_left = '0;
		end else if (zc && window == ZC_ARMED) begin
			// capture half the count, clamped; a wrapped counter reads as the clamp
			if (cnt_wrapped || (period_cnt >> 1) >= CNT_W'(lim_period))
				per = lim_period;
			else
				per = PER_W'(period_cnt >> 1);
			cnt_wrapped = 1'b0;
			period_cnt  = '0;
			hist_sum = hist_sum - SUM_W'(hist[hist_slot]) + SUM_W'(per);
			hist[hist_slot] = per;
			hist_slot = (hist_slot == SLOT_W'(HIST_DEPTH - 1)) ? '0 : hist_slot + 1'b1;
			avg_now = PER_W'(hist_sum / AVG_DIV);
			if (avg_now >= lag_thr && avg_now > lag_off)
				dly_us = avg_now - lag_off;
			else
				dly_us = dly_min;
			dly_left = DLY_W'(dly_us) << 1;
			if (dly_left == '0)
				dly_left = DLY_W'(1);
			window = ZC_DELAY;
		end else begin
			period_cnt = period_cnt + 1'b1;
			if (period_cnt == '0)
				cnt_wrapped = 1'b1;
			if (dly_left != '0) begin
				dly_left = dly_left - 1'b1;
				if (dly_left == '0) begin
					if (window == ZC_DELAY) begin
						window = ZC_BLANK;
						if (run) begin
							step = (step >= STEP_LAST) ? '0 : step + 1'b1;
							advanced = 1'b1;
						end
						dly_left = (blank_len == '0) ? DLY_W'(1) : DLY_W'(blank_len);
					end else if (window == ZC_BLANK) begin
						window = ZC_ARMED;
					end
				end
			end
		end
		avg_now      = PER_W'(hist_sum / AVG_DIV);
		w.step       = step;
		w.commutated = advanced;
		w.hi_ph      = HIGH_OF_STEP[step];
		w.lo_ph      = LOW_OF_STEP[step];
		w.sn_ph      = SENSE_OF_STEP[step];
		w.rising     = step[0];
		w.healthy    = (avg_now >= good_lo) && (avg_now <= good_hi);
		w.avg        = avg_now;
		return w;
	endfunction

	task automatic check_field(input string fname, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (got_v !== exp_v) begin
			mismatches++;
			$display("%0t ns: %s expected %0d got %0d", $time, fname, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			pending_drive.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (pending_drive.size() == 0) begin
					mismatches++;
					$display("%0t ns: result with no request waiting, step %0d avg %0d",
						$time, result.step_now, result.average_half_period);
				end else begin
					want = pending_drive.pop_front();
					check_field("step_now", 16'(want.step), 16'(result.step_now));
					check_field("commutated", 16'(want.commutated), 16'(result.commutated));
					check_field("high_phase", 16'(want.hi_ph), 16'(result.high_phase));
					check_field("low_phase", 16'(want.lo_ph), 16'(result.low_phase));
					check_field("sense_phase", 16'(want.sn_ph), 16'(result.sense_phase));
					check_field("edge_rising", 16'(want.rising), 16'(result.edge_rising));
					check_field("healthy_rotation", 16'(want.healthy),
						16'(result.healthy_rotation));
					check_field("average_half_period", 16'(want.avg),
						16'(result.average_half_period));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_MAX_PERIOD:   lim_period = cfg.data[PER_W-1:0];
					CFG_GOOD_MIN:     good_lo    = cfg.data[PER_W-1:0];
					CFG_GOOD_MAX:     good_hi    = cfg.data[PER_W-1:0];
					CFG_LAG_THRESH:   lag_thr    = cfg.data[PER_W-1:0];
					CFG_LAG_OFFSET:   lag_off    = cfg.data[PER_W-1:0];
					CFG_MIN_DELAY:    dly_min    = cfg.data[PER_W-1:0];
					CFG_BLANK:        blank_len  = cfg.data[BLANK_W-1:0];
					CFG_START_PERIOD: start_per  = cfg.data[PER_W-1:0];
					default: ;
				endcase
			end
			if (tick.valid && tick.ready)
				pending_drive.push_back(predict_drive(tick.opcode, tick.zero_cross,
					tick.run_enable, tick.start_step));
			outstanding = pending_drive.size();
		end
	end

endmodule

/* test/tb_sensorless_bldc_commutation_unit.sv */
// Stimulus, clock, reset and verdict for the sensorless commutation unit.
module tb_sensorless_bldc_commutation_unit import sbc_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 250;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [CFG_IDX_W-1:0] UNUSED_CFG_IDX = CFG_IDX_W'(15);

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   send_idle;
	int   recv_idle;
	logic hold_req;

	sbc_tick_if   tick_ch ();
	sbc_result_if result_ch ();
	sbc_cfg_if    cfg_ch ();

	sensorless_bldc_commutation_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	sbc_commutation_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #2 clk = ~clk;

	// offer one request, idling at random first; leaves valid high
	task automatic send_tick(input logic op, input logic zc, input logic run,
			input logic [STEP_W-1:0] ss);
		while ($urandom_range(0, 99) < send_idle) begin
			tick_ch.valid = 1'b0;
			@(negedge clk);
		end
		tick_ch.valid      = 1'b1;
		tick_ch.opcode     = op;
		tick_ch.zero_cross = zc;
		tick_ch.run_enable = run;
		tick_ch.start_step = ss;
		do @(posedge clk); while (!tick_ch.ready);
		@(negedge clk);
	endtask

	// drop the tick channel and wait until every result has come back
	task automatic settle();
		tick_ch.valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] narrow_data(input int v);
		// junk in the bits above the 13-bit register
		return {3'($urandom), PER_W'(v)};
	endfunction

	task automatic program_regs(input int max_p, input int good_min, input int good_max,
			input int lag_thr, input int lag_off, input int min_dly, input int blank,
			input int start_p);
		settle();
		write_reg(CFG_MAX_PERIOD, narrow_data(max_p));
		write_reg(CFG_GOOD_MIN, narrow_data(good_min));
		write_reg(CFG_GOOD_MAX, narrow_data(good_max));
		write_reg(CFG_LAG_THRESH, narrow_data(lag_thr));
		write_reg(CFG_LAG_OFFSET, narrow_data(lag_off));
		write_reg(CFG_MIN_DELAY, narrow_data(min_dly));
		write_reg(CFG_BLANK, CFG_DATA_W'(blank));
		write_reg(CFG_START_PERIOD, narrow_data(start_p));
		write_reg(UNUSED_CFG_IDX, CFG_DATA_W'($urandom));
		cfg_ch.valid = 1'b0;
	endtask

	task automatic random_regs();
		program_regs($urandom_range(1, 400), $urandom_range(0, 200), $urandom_range(50, 500),
			$urandom_range(0, 150), $urandom_range(0, 120), $urandom_range(1, 40),
			$urandom_range(1, 40), $urandom_range(0, 300));
	endtask

	// spinning motor: a crossing every period ticks, with noise crossings and rare restarts
	task automatic motor_ticks(input int n, input int period);
		int   since;
		int   r;
		logic zc;
		since = 0;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				send_tick(1'b1, 1'($urandom), 1'($urandom), 3'($urandom));
			end else begin
				since++;
				zc = (since >= period) || (r >= 95);
				if (zc)
					since = 0;
				send_tick(1'b0, zc, $urandom_range(0, 99) < 92, 3'($urandom));
			end
		end
	endtask

	// receiver: random back-pressure, plus a long hold-off on request
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				result_ch.ready = 1'b0;
			end else begin
				result_ch.ready = ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (tick_ch.valid && tick_ch.ready) ||
					(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		hold_req  = 1'b0;
		send_idle = 7;
		recv_idle = 80;
		tick_ch.valid      = 1'b0;
		tick_ch.opcode     = 1'b0;
		tick_ch.zero_cross = 1'b0;
		tick_ch.run_enable = 1'b0;
		tick_ch.start_step = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// reset values: restarts with in-range and out-of-range steps, capture, crossing ignored while delaying
		send_tick(1'b1, 1'b0, 1'b0, 3'd5);
		send_tick(1'b1, 1'b0, 1'b0, 3'd7);
		send_tick(1'b1, 1'b1, 1'b1, 3'd6);
		send_tick(1'b0, 1'b0, 1'b0, 3'd0);
		send_tick(1'b0, 1'b1, 1'b1, 3'd3);
		send_tick(1'b0, 1'b1, 1'b1, 3'd4);
		send_tick(1'b0, 1'b0, 1'b1, 3'd2);

		// short delays so a few commutations happen quickly
		program_regs(3, 0, 1, 0, 0, 1, 2, 0);
		motor_ticks(14, 4);

		repeat (3) begin
			random_regs();
			motor_ticks(100, $urandom_range(6, 120));
		end

		send_idle = 80;
		recv_idle = 7;
		random_regs();
		motor_ticks(50, $urandom_range(6, 120));
		hold_req = 1'b1;
		motor_ticks(50, $urandom_range(6, 120));
		random_regs();
		motor_ticks(50, $urandom_range(6, 120));
		settle();
		motor_ticks(50, $urandom_range(6, 120));
		random_regs();
		motor_ticks(100, $urandom_range(6, 120));

		send_idle = 0;
		recv_idle = 0;
		// upper extremes: longest delay and blanking loads, crossings ignored while delaying
		program_regs(8191, 0, 8191, 8191, 8191, 8191, 65535, 8191);
		send_tick(1'b1, 1'b0, 1'b0, 3'd4);
		send_tick(1'b0, 1'b1, 1'b1, 3'd0);
		repeat (20)
			send_tick(1'b0, 1'($urandom), 1'b1, 3'($urandom));
		send_tick(1'b1, 1'b1, 1'b1, 3'd6);

		// lower extremes: zero delay and zero blanking load as one count
		program_regs(1, 0, 0, 0, 0, 0, 0, 0);
		motor_ticks(40, 3);

		random_regs();
		hold_req = 1'b1;
		motor_ticks(100, $urandom_range(6, 120));
		random_regs();
		motor_ticks(100, $urandom_range(6, 120));

		settle();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
